// ----- hdl/assert_macros.svh -----
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion that is switched off while reset is active.
`define PFE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PFE_ASSERT(lbl, clk, rstn, prop, msg)
`define PFE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- hdl/pfe_pkg.sv -----
`default_nettype none

package pfe_pkg;

    // Character codes.
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;

    localparam int unsigned RESULT_WIDTH = 32;
    localparam int unsigned STATUS_WIDTH = 3;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_EMPTY     = 3'd4
    } pfe_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_FINISH
    } pfe_state_t;

    // Request to the shared multiply/divide unit.
    typedef struct packed {
        logic start;
        logic is_div;
    } pfe_md_req_t;

endpackage

`default_nettype wire

// ----- hdl/pfe_if.sv -----
`default_nettype none

// Input channel: one character of the expression per item.
interface pfe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       expr_end;

    modport source (output valid, output char_code, output expr_end, input ready);
    modport sink   (input valid, input char_code, input expr_end, output ready);
endinterface

// Output channel: one result item per expression.
interface pfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic [2:0]         status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

`default_nettype wire

// ----- hdl/pfe_muldiv.sv -----
`default_nettype none

// Shared iterative unit: shift-add multiply (low W bits of the product) or
// restoring signed division truncated toward zero, one bit per cycle.
module pfe_muldiv #(
    parameter int unsigned W = 32
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  pfe_pkg::pfe_md_req_t      req,
    input  wire [W-1:0]               left,
    input  wire [W-1:0]               right,
    output logic                      done,
    output logic [W-1:0]              result
);
    import pfe_pkg::*;

    localparam int unsigned CW = $clog2(W);

    logic          busy_reg;
    logic          fix_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          is_div_reg;
    logic          neg_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  result_reg;
    logic [W:0]    trial;
    logic [W-1:0]  left_mag;
    logic [W-1:0]  right_mag;

    assign trial     = {acc_reg, x_reg[W-1]} - {1'b0, y_reg};
    assign left_mag  = left[W-1] ? (~left + W'(1)) : left;
    assign right_mag = right[W-1] ? (~right + W'(1)) : right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= fix_reg;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                fix_reg  <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    fix_reg  <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            else
            begin
                fix_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            is_div_reg <= req.is_div;
            acc_reg    <= '0;
            if (req.is_div)
            begin
                x_reg   <= left_mag;
                y_reg   <= right_mag;
                neg_reg <= left[W-1] ^ right[W-1];
            end
            else
            begin
                x_reg   <= right;
                y_reg   <= left;
                neg_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!trial[W])
                begin
                    acc_reg <= trial[W-1:0];
                    x_reg   <= {x_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_reg <= {acc_reg[W-2:0], x_reg[W-1]};
                    x_reg   <= {x_reg[W-2:0], 1'b0};
                end
            end
            else
            begin
                if (x_reg[0])
                begin
                    acc_reg <= acc_reg + y_reg;
                end
                x_reg <= {1'b0, x_reg[W-1:1]};
                y_reg <= {y_reg[W-2:0], 1'b0};
            end
        end

        if (fix_reg)
        begin
            if (is_div_reg)
            begin
                result_reg <= neg_reg ? (~x_reg + W'(1)) : x_reg;
            end
            else
            begin
                result_reg <= acc_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- hdl/postfix_expression_evaluator.sv -----
// Postfix expression evaluator: one character item in, one result item per expression.
// A new character is accepted only in S_IDLE. A digit or an ignored operator is
// handled there; '+', '-' and a divide by zero also pass through S_READ, and '*'
// and divide wait in S_WAIT for the iterative multiply/divide unit. An item flagged
// as last then goes to S_FINISH to load the output register, which holds until taken.
// Reset clears the state machine, stack depth, status and output valid. Stack
// memory contents are not cleared; no entry is read before it is written.
`default_nettype none

`include "assert_macros.svh"

module postfix_expression_evaluator #(
    parameter int unsigned STACK_DEPTH = 32,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    pfe_in_if.sink     in_ch,
    pfe_out_if.source  out_ch
);
    import pfe_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned W  = VALUE_WIDTH;

    // The operand stack lives in a synchronous memory. The top entry is also
    // mirrored in top_reg, so an operator only needs one memory read for its
    // left operand, and the end of an expression needs none.
    logic [W-1:0] stack_mem [STACK_DEPTH];
    logic [W-1:0] rdata_reg;

    pfe_state_t   state_reg, state_next;
    logic [DW-1:0] depth_reg, depth_next;
    pfe_status_t  err_reg, err_next;
    logic [W-1:0] top_reg, top_next;
    logic [7:0]   ch_reg, ch_next;
    logic         last_reg, last_next;

    logic         out_valid_reg;
    logic signed [RESULT_WIDTH-1:0] out_value_reg;
    logic [STATUS_WIDTH-1:0]        out_status_reg;
    logic         out_load;
    logic signed [RESULT_WIDTH-1:0] out_value;
    pfe_status_t  out_status;

    logic          in_acc;
    logic          is_digit;
    logic [3:0]    digit;
    logic [DW-1:0] below_top;
    logic [AW-1:0] below_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [W-1:0]  wr_data;
    logic          rd_en;
    logic          wb_en;
    logic [W-1:0]  wb_value;
    logic          flag;
    pfe_status_t   flag_code;

    pfe_md_req_t   md_req;
    logic          md_done;
    logic [W-1:0]  md_result;

    pfe_muldiv #(
        .W (W)
    ) u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .left   (rdata_reg),
        .right  (top_reg),
        .done   (md_done),
        .result (md_result)
    );

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign digit       = 4'(in_ch.char_code - CH_ZERO);
    assign below_top   = depth_reg - DW'(2);
    assign below_addr  = below_top[AW-1:0];

    always_comb
    begin
        is_digit = 1'b0;
        if (in_ch.char_code inside {[CH_ZERO:CH_NINE]})
        begin
            is_digit = 1'b1;
        end
    end

    // Sequencer: next state, stack bookkeeping and memory port control.
    always_comb
    begin
        state_next = state_reg;
        depth_next = depth_reg;
        err_next   = err_reg;
        top_next   = top_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        wr_en      = 1'b0;
        wr_addr    = depth_reg[AW-1:0];
        wr_data    = top_reg;
        rd_en      = 1'b0;
        wb_en      = 1'b0;
        wb_value   = '0;
        md_req     = '0;
        flag       = 1'b0;
        flag_code  = ST_OK;
        out_load   = 1'b0;
        out_value  = '0;
        out_status = ST_OK;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    ch_next   = in_ch.char_code;
                    last_next = in_ch.expr_end;
                    if (is_digit)
                    begin
                        // A digit on a full stack is dropped.
                        if (depth_reg == DW'(STACK_DEPTH))
                        begin
                            flag      = 1'b1;
                            flag_code = ST_OVERFLOW;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_data    = W'(digit);
                            top_next   = W'(digit);
                            depth_next = depth_reg + DW'(1);
                        end
                        state_next = in_ch.expr_end ? S_FINISH : S_IDLE;
                    end
                    else if (depth_reg < DW'(2))
                    begin
                        // Too few operands: the operator is ignored.
                        flag       = 1'b1;
                        flag_code  = ST_UNDERFLOW;
                        state_next = in_ch.expr_end ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                // Left operand is in rdata_reg, right operand in top_reg.
                case (ch_reg)
                    CH_PLUS:
                    begin
                        wb_en    = 1'b1;
                        wb_value = rdata_reg + top_reg;
                    end
                    CH_MINUS:
                    begin
                        wb_en    = 1'b1;
                        wb_value = rdata_reg - top_reg;
                    end
                    CH_STAR:
                    begin
                        md_req.start  = 1'b1;
                        md_req.is_div = 1'b0;
                        state_next    = S_WAIT;
                    end
                    default:
                    begin
                        if (top_reg == '0)
                        begin
                            flag      = 1'b1;
                            flag_code = ST_DIVZERO;
                            wb_en     = 1'b1;
                            wb_value  = '0;
                        end
                        else
                        begin
                            md_req.start  = 1'b1;
                            md_req.is_div = 1'b1;
                            state_next    = S_WAIT;
                        end
                    end
                endcase
            end

            S_WAIT:
            begin
                if (md_done)
                begin
                    wb_en    = 1'b1;
                    wb_value = md_result;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load = 1'b1;
                    if (depth_reg == '0)
                    begin
                        out_value  = '0;
                        out_status = (err_reg == ST_OK) ? ST_EMPTY : err_reg;
                    end
                    else
                    begin
                        out_value  = RESULT_WIDTH'($signed(top_reg));
                        out_status = err_reg;
                    end
                    depth_next = '0;
                    err_next   = ST_OK;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Two operands popped, one result pushed in place of the left one.
        if (wb_en)
        begin
            wr_en      = 1'b1;
            wr_addr    = below_addr;
            wr_data    = wb_value;
            top_next   = wb_value;
            depth_next = depth_reg - DW'(1);
            state_next = last_reg ? S_FINISH : S_IDLE;
        end

        // Only the first error of an expression is kept.
        if (flag && (err_reg == ST_OK))
        begin
            err_next = flag_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        ch_reg   <= ch_next;
        last_reg <= last_next;
        if (out_load)
        begin
            out_value_reg  <= out_value;
            out_status_reg <= out_status;
        end
    end

    // Stack memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            stack_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= stack_mem[below_addr];
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.status       = out_status_reg;

    `PFE_ASSERT(a_depth_bound, clk, rst_n, depth_reg <= DW'(STACK_DEPTH), "stack too deep")
    `PFE_ASSERT(a_md_done_in_wait, clk, rst_n, md_done |-> (state_reg == S_WAIT), "stray done")
    `PFE_ASSERT(a_finish_clears, clk, rst_n, out_load |=> (depth_reg == '0) && (err_reg == ST_OK) && out_valid_reg, "expression end did not clear stack and status")
    `PFE_ASSERT(a_writeback_depth, clk, rst_n, wb_en |-> (depth_reg >= DW'(2)), "result written back with fewer than two operands")

endmodule

`default_nettype wire
